/* sv/gated_pulse_feature_extractor_macros.svh */
// Assertion macros for the gated pulse feature extractor.
// Included by the top level; expects clk and arst_n in scope.
`ifndef GATED_PULSE_FEATURE_EXTRACTOR_MACROS_SVH
`define GATED_PULSE_FEATURE_EXTRACTOR_MACROS_SVH

// Condition holds at every clock edge out of reset
`define GPFE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define GPFE_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent
`define GPFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/gpfe_pkg.sv */
// Shared types and constants of the gated pulse feature extractor.
// No dependencies; used by every other file of the block but the assertion macro header.
package gpfe_pkg;

	// Sizing
	localparam int MAX_SAMPLES   = 4096;
	localparam int SAMPLE_BITS   = 16;
	localparam int FRACTION_BITS = 8;

	// Field widths
	localparam int START_W = 12;
	localparam int LEN_W   = 13;
	localparam int SUM_W   = 28;
	localparam int PIDX_W  = 12;
	localparam int CNT_W   = 13;
	localparam int AIDX_W  = 13;
	localparam int POS_W   = 13;
	localparam int POS_CAP = 4095 + MAX_SAMPLES;

	// Divider widths: signed difference and its magnitude
	localparam int NUM_W  = SAMPLE_BITS + 2;
	localparam int MAG_W  = SAMPLE_BITS + 1;
	localparam int STEP_W = $clog2(FRACTION_BITS + 1);

	// Snapshot queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_GATE_START  = 2'd0,
		REG_GATE_LENGTH = 2'd1,
		REG_THRESHOLD   = 2'd2
	} reg_idx_t;

	// Snapshot of one waveform's statistics
	typedef struct packed {
		logic signed [SUM_W-1:0]       sum;
		logic signed [SAMPLE_BITS-1:0] peak;
		logic [PIDX_W-1:0]             peak_idx;
		logic [CNT_W-1:0]              count;
		logic                          cross_seen;
		logic [AIDX_W-1:0]             cross_pos;
		logic signed [SAMPLE_BITS-1:0] below;
		logic signed [SAMPLE_BITS-1:0] above;
		logic signed [SAMPLE_BITS-1:0] thr;
	} rec_t;

	// Front to queue
	typedef struct packed {
		logic push;
		rec_t rec;
	} push_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* sv/gpfe_channels.sv */
// Handshake channel interfaces of the gated pulse feature extractor.
// Depends on gpfe_pkg for field widths.
interface gpfe_smp_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [gpfe_pkg::SAMPLE_BITS-1:0] sample;
	logic                                   last;

	modport source (output valid, sample, last, input ready);
	modport sink   (input valid, sample, last, output ready);
endinterface

interface gpfe_res_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [gpfe_pkg::SUM_W-1:0]       gate_sum;
	logic signed [gpfe_pkg::SAMPLE_BITS-1:0] peak_value;
	logic [gpfe_pkg::PIDX_W-1:0]             peak_index;
	logic [gpfe_pkg::CNT_W-1:0]              over_count;
	logic                                   over_found;
	logic signed [gpfe_pkg::AIDX_W-1:0]      arrival_index;
	logic [gpfe_pkg::FRACTION_BITS-1:0]      arrival_fraction;
	logic                                   arrival_found;

	modport source (output valid, gate_sum, peak_value, peak_index, over_count,
		over_found, arrival_index, arrival_fraction, arrival_found, input ready);
	modport sink (input valid, gate_sum, peak_value, peak_index, over_count,
		over_found, arrival_index, arrival_fraction, arrival_found, output ready);
endinterface

/* sv/gpfe_front.sv */
// Front end: takes one sample per cycle while the queue has room, keeps the gate statistics and
// pushes a snapshot when the gate closes or the waveform ends. Uses gpfe_pkg.
module gpfe_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [gpfe_pkg::START_W-1:0]           gate_start,
	input  logic [gpfe_pkg::LEN_W-1:0]             gate_length,
	input  logic signed [gpfe_pkg::SAMPLE_BITS-1:0] threshold,
	input  gpfe_pkg::q_stat_t                      q_stat,
	output gpfe_pkg::push_t                        push,
	gpfe_smp_if.sink                               smp
);

	logic [gpfe_pkg::POS_W-1:0]              pos_q;
	logic signed [gpfe_pkg::SAMPLE_BITS-1:0] prev_q;
	logic signed [gpfe_pkg::SUM_W-1:0]       sum_q, sum_d;
	logic signed [gpfe_pkg::SAMPLE_BITS-1:0] max_q, max_d;
	logic [gpfe_pkg::PIDX_W-1:0]             maxpos_q, maxpos_d;
	logic [gpfe_pkg::CNT_W-1:0]              cnt_q, cnt_d;
	logic                                    seen_q, seen_d;
	logic [gpfe_pkg::AIDX_W-1:0]             cpos_q, cpos_d;
	logic signed [gpfe_pkg::SAMPLE_BITS-1:0] below_q, below_d;
	logic signed [gpfe_pkg::SAMPLE_BITS-1:0] above_q, above_d;
	logic                                    sent_q;

	logic [gpfe_pkg::LEN_W-1:0]   len;
	logic [gpfe_pkg::POS_W:0]     gate_end;
	logic [gpfe_pkg::POS_W-1:0]   rel;
	logic [gpfe_pkg::LEN_W:0]     rel_p1;
	logic                         in_gate;
	logic                         over;
	logic                         emit_gate;
	logic                         emit;
	logic                         accept;

	// Clamp the gate and locate the sample inside it
	always_comb begin
		len = (gate_length > gpfe_pkg::LEN_W'(gpfe_pkg::MAX_SAMPLES)) ?
			gpfe_pkg::LEN_W'(gpfe_pkg::MAX_SAMPLES) : gate_length;
		gate_end = (gpfe_pkg::POS_W+1)'(gate_start) + (gpfe_pkg::POS_W+1)'(len);
		rel      = pos_q - gpfe_pkg::POS_W'(gate_start);
		rel_p1   = (gpfe_pkg::LEN_W+1)'(rel) + (gpfe_pkg::LEN_W+1)'(1);
		in_gate  = !sent_q && (len != '0) &&
			(pos_q >= gpfe_pkg::POS_W'(gate_start)) &&
			((gpfe_pkg::POS_W+1)'(pos_q) < gate_end);
		over     = smp.sample > threshold;
	end

	// Fold the current sample into the statistics
	always_comb begin
		sum_d    = sum_q;
		max_d    = max_q;
		maxpos_d = maxpos_q;
		cnt_d    = cnt_q;
		seen_d   = seen_q;
		cpos_d   = cpos_q;
		below_d  = below_q;
		above_d  = above_q;
		if (in_gate) begin
			sum_d = sum_q + gpfe_pkg::SUM_W'(smp.sample);
			if ((rel == '0) || (smp.sample > max_q)) begin
				max_d    = smp.sample;
				maxpos_d = rel[gpfe_pkg::PIDX_W-1:0];
			end
			if (over) begin
				cnt_d = cnt_q + gpfe_pkg::CNT_W'(1);
			end
			if (!seen_q && over && (rel_p1 < (gpfe_pkg::LEN_W+1)'(len))) begin
				seen_d  = 1'b1;
				cpos_d  = gpfe_pkg::AIDX_W'(rel);
				below_d = prev_q;
				above_d = smp.sample;
			end
		end
		emit_gate = in_gate && (rel_p1 == (gpfe_pkg::LEN_W+1)'(len));
		emit      = emit_gate || (smp.last && !sent_q);
	end

	assign smp.ready = !q_stat.full;
	assign accept    = smp.valid && smp.ready;

	// Snapshot for the queue
	always_comb begin
		push.push           = accept && emit;
		push.rec.sum        = sum_d;
		push.rec.peak       = max_d;
		push.rec.peak_idx   = maxpos_d;
		push.rec.count      = cnt_d;
		push.rec.cross_seen = seen_d;
		push.rec.cross_pos  = cpos_d;
		push.rec.below      = below_d;
		push.rec.above      = above_d;
		push.rec.thr        = threshold;
	end

	// Hold waveform state; clear it after the last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			prev_q   <= '0;
			sum_q    <= '0;
			max_q    <= {1'b1, {(gpfe_pkg::SAMPLE_BITS-1){1'b0}}};
			maxpos_q <= '0;
			cnt_q    <= '0;
			seen_q   <= 1'b0;
			cpos_q   <= '0;
			below_q  <= '0;
			above_q  <= '0;
			sent_q   <= 1'b0;
		end else if (accept) begin
			if (smp.last) begin
				pos_q    <= '0;
				prev_q   <= '0;
				sum_q    <= '0;
				max_q    <= {1'b1, {(gpfe_pkg::SAMPLE_BITS-1){1'b0}}};
				maxpos_q <= '0;
				cnt_q    <= '0;
				seen_q   <= 1'b0;
				cpos_q   <= '0;
				below_q  <= '0;
				above_q  <= '0;
				sent_q   <= 1'b0;
			end else begin
				if (pos_q < gpfe_pkg::POS_W'(gpfe_pkg::POS_CAP)) begin
					pos_q <= pos_q + gpfe_pkg::POS_W'(1);
				end
				prev_q   <= smp.sample;
				sum_q    <= sum_d;
				max_q    <= max_d;
				maxpos_q <= maxpos_d;
				cnt_q    <= cnt_d;
				seen_q   <= seen_d;
				cpos_q   <= cpos_d;
				below_q  <= below_d;
				above_q  <= above_d;
				sent_q   <= sent_q | emit_gate;
			end
		end
	end

endmodule

/* sv/gpfe_queue.sv */
// Short FIFO of statistics snapshots between front and back.
// Uses gpfe_pkg for the record type and depth.
module gpfe_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  gpfe_pkg::push_t   push,
	input  logic              pop,
	output gpfe_pkg::rec_t    head,
	output gpfe_pkg::q_stat_t q_stat
);

	gpfe_pkg::rec_t              mem_q [gpfe_pkg::QDEPTH];
	logic [gpfe_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [gpfe_pkg::QCNT_W-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == gpfe_pkg::QCNT_W'(gpfe_pkg::QDEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = mem_q[rd_q];

	// Store pushed snapshots
	always_ff @(posedge clk) begin
		if (push.push) begin
			mem_q[wr_q] <= push.rec;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.push) begin
				wr_q <= wr_q + gpfe_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + gpfe_pkg::QPTR_W'(1);
			end
			if (push.push && !pop) begin
				cnt_q <= cnt_q + gpfe_pkg::QCNT_W'(1);
			end else if (pop && !push.push) begin
				cnt_q <= cnt_q - gpfe_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

/* sv/gpfe_back.sv */
// Back end: takes snapshots from the queue, works out the crossing fraction
// with a restoring divider (one quotient bit a cycle) and holds the result.
// Uses gpfe_pkg and gpfe_res_if.
module gpfe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  gpfe_pkg::rec_t    head,
	input  gpfe_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              busy,
	gpfe_res_if.source        res
);

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	state_t                                  state_q;
	gpfe_pkg::rec_t                          rec_q;
	logic [gpfe_pkg::MAG_W-1:0]              rem_q;
	logic [gpfe_pkg::MAG_W-1:0]              den_q;
	logic [gpfe_pkg::FRACTION_BITS-1:0]      quo_q;
	logic [gpfe_pkg::STEP_W-1:0]             step_q;
	logic                                    zero_q;
	logic                                    sat_q;

	logic                                    ovalid_q;
	logic signed [gpfe_pkg::SUM_W-1:0]       osum_q;
	logic signed [gpfe_pkg::SAMPLE_BITS-1:0] opeak_q;
	logic [gpfe_pkg::PIDX_W-1:0]             opidx_q;
	logic [gpfe_pkg::CNT_W-1:0]              ocnt_q;
	logic                                    oover_q;
	logic signed [gpfe_pkg::AIDX_W-1:0]      oaidx_q;
	logic [gpfe_pkg::FRACTION_BITS-1:0]      ofrac_q;
	logic                                    afound_q;

	logic signed [gpfe_pkg::NUM_W-1:0]       num, den, num_n, den_n;
	logic [gpfe_pkg::MAG_W:0]                rem2;
	logic                                    fits;
	logic                                    div_done;
	logic                                    out_free;
	logic                                    finish;
	logic                                    over;
	logic [gpfe_pkg::FRACTION_BITS-1:0]      frac;

	// Sign-normalize numerator and denominator of the incoming snapshot
	always_comb begin
		num = gpfe_pkg::NUM_W'(head.thr) - gpfe_pkg::NUM_W'(head.below);
		den = gpfe_pkg::NUM_W'(head.above) - gpfe_pkg::NUM_W'(head.below);
		if (den < 0) begin
			num_n = -num;
			den_n = -den;
		end else begin
			num_n = num;
			den_n = den;
		end
	end

	// One restoring step
	always_comb begin
		rem2 = {rem_q, 1'b0};
		fits = rem2 >= {1'b0, den_q};
	end

	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;
	assign busy     = (state_q == ST_DIV);
	assign div_done = zero_q || sat_q ||
		(step_q == gpfe_pkg::STEP_W'(gpfe_pkg::FRACTION_BITS));
	assign out_free = !ovalid_q || res.ready;
	assign finish   = (state_q == ST_DIV) && div_done && out_free;
	assign over     = (rec_q.count != '0);

	// Saturate the quotient
	always_comb begin
		if (!rec_q.cross_seen || zero_q) begin
			frac = '0;
		end else if (sat_q) begin
			frac = '1;
		end else begin
			frac = quo_q;
		end
	end

	// Sequence the divider and hold the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rec_q    <= '0;
			rem_q    <= '0;
			den_q    <= '0;
			quo_q    <= '0;
			step_q   <= '0;
			zero_q   <= 1'b0;
			sat_q    <= 1'b0;
			ovalid_q <= 1'b0;
			osum_q   <= '0;
			opeak_q  <= '0;
			opidx_q  <= '0;
			ocnt_q   <= '0;
			oover_q  <= 1'b0;
			oaidx_q  <= '0;
			ofrac_q  <= '0;
			afound_q <= 1'b0;
		end else begin
			// Drop the result once taken, unless a new one replaces it
			if (ovalid_q && res.ready && !finish) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						rec_q   <= head;
						rem_q   <= num_n[gpfe_pkg::MAG_W-1:0];
						den_q   <= den_n[gpfe_pkg::MAG_W-1:0];
						quo_q   <= '0;
						step_q  <= '0;
						zero_q  <= (den_n == '0) || num_n[gpfe_pkg::NUM_W-1] ||
							(num_n == '0);
						sat_q   <= num_n >= den_n;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!div_done) begin
						rem_q  <= fits ? gpfe_pkg::MAG_W'(rem2 - {1'b0, den_q})
							: rem2[gpfe_pkg::MAG_W-1:0];
						quo_q  <= {quo_q[gpfe_pkg::FRACTION_BITS-2:0], fits};
						step_q <= step_q + gpfe_pkg::STEP_W'(1);
					end else if (finish) begin
						ovalid_q <= 1'b1;
						osum_q   <= over ? rec_q.sum : '0;
						opeak_q  <= over ? rec_q.peak : '0;
						opidx_q  <= rec_q.peak_idx;
						ocnt_q   <= rec_q.count;
						oover_q  <= over;
						oaidx_q  <= rec_q.cross_seen ?
							(rec_q.cross_pos - gpfe_pkg::AIDX_W'(1)) : '0;
						ofrac_q  <= frac;
						afound_q <= rec_q.cross_seen;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid            = ovalid_q;
	assign res.gate_sum         = osum_q;
	assign res.peak_value       = opeak_q;
	assign res.peak_index       = opidx_q;
	assign res.over_count       = ocnt_q;
	assign res.over_found       = oover_q;
	assign res.arrival_index    = oaidx_q;
	assign res.arrival_fraction = ofrac_q;
	assign res.arrival_found    = afound_q;

endmodule

/* sv/gated_pulse_feature_extractor.sv */
// Top level of the gated pulse feature extractor: configuration registers,
// front, snapshot queue and divider back end. Uses gpfe_pkg, the channel
// interfaces and the assertion macro header.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+----------------------------------
//  smp      | in        | valid/ready      | sample, last
//  res      | out       | valid/ready      | gate_sum .. arrival_found
//  apb      | in        | psel/penable     | paddr, pwdata, prdata
//
// The front takes one sample every cycle while the queue has room.
// Once a snapshot reaches the queue head, the back end pops it, runs the bit-serial
// divider and registers the result.
// Reset is asynchronous, active low, and takes effect at once; no clearing pass.
// A stalled result holds in the output register; two more snapshots fit in
// the queue before the sample input stalls.
module gated_pulse_feature_extractor (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [gpfe_pkg::PADDR_W-1:0]       paddr,
	input  logic [gpfe_pkg::PDATA_W-1:0]       pwdata,
	output logic [gpfe_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready,
	gpfe_smp_if.sink                           smp,
	gpfe_res_if.source                         res
);

	`include "gated_pulse_feature_extractor_macros.svh"

	logic [gpfe_pkg::START_W-1:0]           gate_start_q;
	logic [gpfe_pkg::LEN_W-1:0]             gate_length_q;
	logic signed [gpfe_pkg::SAMPLE_BITS-1:0] threshold_q;

	gpfe_pkg::reg_idx_t reg_idx;
	logic               wr_en;
	gpfe_pkg::push_t    push;
	gpfe_pkg::q_stat_t  q_stat;
	gpfe_pkg::rec_t     head;
	logic               pop;
	logic               back_busy;

	assign pready  = 1'b1;
	assign reg_idx = gpfe_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_start_q  <= '0;
			gate_length_q <= gpfe_pkg::LEN_W'(4096);
			threshold_q   <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				gpfe_pkg::REG_GATE_START:  gate_start_q  <= pwdata[gpfe_pkg::START_W-1:0];
				gpfe_pkg::REG_GATE_LENGTH: gate_length_q <= pwdata[gpfe_pkg::LEN_W-1:0];
				gpfe_pkg::REG_THRESHOLD:   threshold_q   <= pwdata[gpfe_pkg::SAMPLE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (reg_idx)
			gpfe_pkg::REG_GATE_START:  prdata = gpfe_pkg::PDATA_W'(gate_start_q);
			gpfe_pkg::REG_GATE_LENGTH: prdata = gpfe_pkg::PDATA_W'(gate_length_q);
			gpfe_pkg::REG_THRESHOLD:   prdata = gpfe_pkg::PDATA_W'($unsigned(threshold_q));
			default:                   prdata = '0;
		endcase
	end

	gpfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.gate_start  (gate_start_q),
		.gate_length (gate_length_q),
		.threshold   (threshold_q),
		.q_stat      (q_stat),
		.push        (push),
		.smp         (smp)
	);

	gpfe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	gpfe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.busy   (back_busy),
		.res    (res)
	);

	`GPFE_ASSERT_IMPLY(a_no_push_when_full, push.push, !q_stat.full,
		"snapshot pushed into full queue")
	`GPFE_ASSERT_IMPLY(a_pop_only_idle, pop, !q_stat.empty && !back_busy,
		"queue popped while empty or busy")
	`GPFE_ASSERT_IMPLY(a_no_over_zero, res.valid && !res.over_found,
		res.over_count == '0 && res.gate_sum == '0 && res.peak_value == '0,
		"stats not cleared without over samples")
	`GPFE_ASSERT_NEXT(a_pop_starts_div, pop, back_busy,
		"divider did not start after pop")

endmodule

/* tb/gpfe_feature_check.sv */
// Feature checker for the gated pulse feature extractor: snoops the register
// port, predicts one feature record per waveform and compares it with the results.
// Depends on gpfe_pkg and the channel interfaces in gpfe_channels.sv.
module gpfe_feature_check
	import gpfe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	gpfe_smp_if                smp,
	gpfe_res_if                res,
	output int                 pending,
	output int                 failures
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [SUM_W-1:0]       gate_sum;
		logic signed [SAMPLE_BITS-1:0] peak_value;
		logic [PIDX_W-1:0]             peak_index;
		logic [CNT_W-1:0]              over_count;
		logic                          over_found;
		logic signed [AIDX_W-1:0]      arrival_index;
		logic [FRACTION_BITS-1:0]      arrival_fraction;
		logic                          arrival_found;
	} feature_t;

	// Register copies
	logic [START_W-1:0]            gate_start;
	logic [LEN_W-1:0]              gate_length;
	logic signed [SAMPLE_BITS-1:0] threshold;

	// Per-waveform accumulators
	logic [POS_W-1:0]              position;
	logic signed [SAMPLE_BITS-1:0] prev_sample;
	logic signed [SUM_W-1:0]       acc_sum;
	logic signed [SAMPLE_BITS-1:0] top_value;
	logic [PIDX_W-1:0]             top_position;
	logic [CNT_W-1:0]              over_n;
	logic                          cross_hit;
	logic [AIDX_W-1:0]             cross_rel;
	logic signed [SAMPLE_BITS-1:0] cross_lo;
	logic signed [SAMPLE_BITS-1:0] cross_hi;
	logic                          gate_done;

	feature_t features[$];

	function automatic void clear_waveform_state();
		position     = '0;
		prev_sample  = '0;
		acc_sum      = '0;
		top_value    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		top_position = '0;
		over_n       = '0;
		cross_hit    = 1'b0;
		cross_rel    = '0;
		cross_lo     = '0;
		cross_hi     = '0;
		gate_done    = 1'b0;
	endfunction

	// Linear interpolation of the crossing point, saturated to the fraction range
	function automatic logic [FRACTION_BITS-1:0] crossing_fraction(
		logic signed [SAMPLE_BITS-1:0] thr,
		logic signed [SAMPLE_BITS-1:0] lo,
		logic signed [SAMPLE_BITS-1:0] hi
	);
		int num;
		int den;
		int q;
		num = int'(thr) - int'(lo);
		den = int'(hi) - int'(lo);
		if (den == 0)
			return '0;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		if (num <= 0)
			return '0;
		q = (num << FRACTION_BITS) / den;
		if (q > (1 << FRACTION_BITS) - 1)
			return '1;
		return q[FRACTION_BITS-1:0];
	endfunction

	function automatic feature_t gate_features();
		feature_t f;
		logic over;
		over = (over_n != 0);
		f.gate_sum   = over ? acc_sum : '0;
		f.peak_value = over ? top_value : '0;
		f.peak_index = top_position;
		f.over_count = over_n;
		f.over_found = over;
		if (cross_hit) begin
			f.arrival_index    = cross_rel - 1'b1;
			f.arrival_fraction = crossing_fraction(threshold, cross_lo, cross_hi);
			f.arrival_found    = 1'b1;
		end else begin
			f.arrival_index    = '0;
			f.arrival_fraction = '0;
			f.arrival_found    = 1'b0;
		end
		return f;
	endfunction

	// Advance the waveform by one sample, queue a record when the gate closes or the waveform ends
	function automatic void take_sample(logic signed [SAMPLE_BITS-1:0] s, logic fin);
		int len;
		int rel;
		len = (gate_length > MAX_SAMPLES) ? MAX_SAMPLES : int'(gate_length);
		if (!gate_done && len > 0 && int'(position) >= int'(gate_start) &&
				int'(position) < int'(gate_start) + len) begin
			rel = int'(position) - int'(gate_start);
			acc_sum = acc_sum + s;
			if (rel == 0 || s > top_value) begin
				top_value    = s;
				top_position = rel[PIDX_W-1:0];
			end
			if (s > threshold)
				over_n = over_n + 1'b1;
			if (!cross_hit && rel + 1 < len && s > threshold) begin
				cross_hit = 1'b1;
				cross_rel = rel[AIDX_W-1:0];
				cross_lo  = prev_sample;
				cross_hi  = s;
			end
			if (rel + 1 == len) begin
				features.push_back(gate_features());
				gate_done = 1'b1;
			end
		end
		if (fin && !gate_done)
			features.push_back(gate_features());
		prev_sample = s;
		if (int'(position) < POS_CAP)
			position = position + 1'b1;
		if (fin)
			clear_waveform_state();
	endfunction

	task automatic report_field(string field, int want, int got);
		$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		failures++;
	endtask

	task automatic check_result();
		feature_t want;
		if (features.size() == 0) begin
			$display("%0t ns: result with none pending, gate_sum %0d, over_count %0d",
				$time, res.gate_sum, res.over_count);
			failures++;
		end else begin
			want = features.pop_front();
			if (res.gate_sum !== want.gate_sum)
				report_field("gate_sum", want.gate_sum, res.gate_sum);
			if (res.peak_value !== want.peak_value)
				report_field("peak_value", want.peak_value, res.peak_value);
			if (res.peak_index !== want.peak_index)
				report_field("peak_index", want.peak_index, res.peak_index);
			if (res.over_count !== want.over_count)
				report_field("over_count", want.over_count, res.over_count);
			if (res.over_found !== want.over_found)
				report_field("over_found", want.over_found, res.over_found);
			if (res.arrival_index !== want.arrival_index)
				report_field("arrival_index", want.arrival_index, res.arrival_index);
			if (res.arrival_fraction !== want.arrival_fraction)
				report_field("arrival_fraction", want.arrival_fraction, res.arrival_fraction);
			if (res.arrival_found !== want.arrival_found)
				report_field("arrival_found", want.arrival_found, res.arrival_found);
		end
	endtask

	// Snoop register writes, check results, then take in the accepted sample
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_start  <= '0;
			gate_length <= LEN_W'(MAX_SAMPLES);
			threshold   <= '0;
			clear_waveform_state();
			features.delete();
			pending  = 0;
			failures = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:2]))
					REG_GATE_START:  gate_start  <= pwdata[START_W-1:0];
					REG_GATE_LENGTH: gate_length <= pwdata[LEN_W-1:0];
					REG_THRESHOLD:   threshold   <= pwdata[SAMPLE_BITS-1:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready)
				check_result();
			if (smp.valid && smp.ready)
				take_sample(smp.sample, smp.last);
			pending = features.size();
		end
	end

endmodule

/* tb/tb.sv */
// Top of the gated pulse feature extractor testbench: clock, reset, register
// writes, waveform stimulus and result back-pressure, plus the verdict.
// Depends on gpfe_pkg, the channel interfaces, the block and gpfe_feature_check.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gpfe_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 pending;
	int                 failures;

	gpfe_smp_if smp_ch();
	gpfe_res_if res_ch();

	gated_pulse_feature_extractor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.smp     (smp_ch),
		.res     (res_ch)
	);

	gpfe_feature_check feature_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.smp      (smp_ch),
		.res      (res_ch),
		.pending  (pending),
		.failures (failures)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	shortint wave[$];
	shortint cur_thr;
	logic    quick;
	int      phase_items;
	int      results_taken;
	int      gs;
	int      glen;

	function automatic shortint clip16(int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return shortint'(v);
	endfunction

	// Register write: setup cycle, then access cycle until pready
	task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(int start, int length, shortint thr);
		write_reg(REG_GATE_START, PDATA_W'(start));
		write_reg(REG_GATE_LENGTH, PDATA_W'(length));
		write_reg(REG_THRESHOLD, PDATA_W'(unsigned'(int'(thr))));
		cur_thr = thr;
	endtask

	// Drop valid, drain every pending result, let the divider go quiet
	task automatic settle();
		smp_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (FRACTION_BITS + 12) @(negedge clk);
	endtask

	// Offer one sample after a random gap; valid stays up for the next one
	task automatic send_sample(shortint s, logic fin);
		int gap;
		gap = quick ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			smp_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		smp_ch.valid  <= 1'b1;
		smp_ch.sample <= s;
		smp_ch.last   <= fin;
		do @(posedge clk); while (!smp_ch.ready);
		@(negedge clk);
	endtask

	task automatic play_wave();
		quick = ($urandom_range(0, 3) == 0);
		foreach (wave[i])
			send_sample(wave[i], i == wave.size() - 1);
	endtask

	// Pulse riding on a baseline at or below threshold, with noise and outliers
	task automatic build_wave();
		int n;
		int onset;
		int slope;
		int base;
		int rise;
		int v;
		wave.delete();
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		base  = int'(cur_thr) - int'($urandom_range(0, 3000));
		onset = $urandom_range(0, n);
		slope = $urandom_range(1, 8000);
		for (int i = 0; i < n; i++) begin
			rise = (i < onset) ? 0 : ((i - onset < 4) ? i - onset + 1 : 4);
			v = base + slope * rise + int'($urandom_range(0, 200)) - 100;
			case ($urandom_range(0, 19))
				0, 1, 2: v = int'(shortint'($urandom));
				3:       v = 32767;
				4:       v = -32768;
				default: ;
			endcase
			wave.push_back(clip16(v));
		end
	endtask

	// Result side: random stalls, quiet stretches and long hold-offs
	initial begin
		int hold;
		res_ch.ready = 1'b0;
		results_taken = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (results_taken == 15 || results_taken == 35 || results_taken == 55)
				hold = 300;
			else if ((results_taken / 20) % 4 == 3)
				hold = 0;
			else
				hold = $urandom_range(0, 10);
			if (hold > 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			results_taken++;
			@(negedge clk);
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		smp_ch.valid  = 1'b0;
		smp_ch.sample = '0;
		smp_ch.last   = 1'b0;
		cur_thr = 0;
		quick   = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Reset registers: crossing on the very first sample, both extremes
		wave = '{5, -3, 7};
		play_wave();
		wave = '{-32768, 32767};
		play_wave();

		// Crossing on the first gate sample; waveform ending before the gate
		settle();
		configure(2, 4, 100);
		wave = '{150, 50, 120, 30, 200, 10};
		play_wave();
		wave = '{50};
		play_wave();

		// Sample before the crossing already above threshold, both slopes
		settle();
		configure(1, 3, 100);
		wave = '{300, 200, 50};
		play_wave();
		wave = '{300, 400, 50, 60};
		play_wave();

		// Empty gate
		settle();
		configure(0, 0, 0);
		wave = '{1, 2, 3};
		play_wave();

		// One-sample gate: over threshold but no crossing allowed
		settle();
		configure(0, 1, -32768);
		wave = '{32767, 5};
		play_wave();
		wave = '{-32768};
		play_wave();

		// Oversized gate length, threshold at the top
		settle();
		configure(0, 8191, 32767);
		wave = '{32767, 32767, -1};
		play_wave();

		// Random phases, each with its own register setting
		for (int ph = 0; ph < 8; ph++) begin
			settle();
			if (ph == 0) begin
				gs = 0;
				glen = 1;
				cur_thr = -32768;
			end else if (ph == 1) begin
				gs = 0;
				glen = 2;
				cur_thr = 32767;
			end else begin
				gs = $urandom_range(0, 8);
				case ($urandom_range(0, 9))
					0:       glen = 0;
					1:       glen = 8191;
					default: glen = $urandom_range(1, 16);
				endcase
				if ($urandom_range(0, 2) == 0)
					cur_thr = shortint'($urandom);
				else
					cur_thr = shortint'(int'($urandom_range(0, 4000)) - 2000);
			end
			configure(gs, glen, cur_thr);
			phase_items = 0;
			while (phase_items < 60) begin
				build_wave();
				play_wave();
				phase_items += wave.size();
			end
		end

		// Latest gate start with the largest gate; waveform ends before it opens
		settle();
		configure(4095, 4096, shortint'($urandom));
		wave.delete();
		repeat (12) wave.push_back(shortint'($urandom));
		play_wave();

		settle();
		if (failures == 0)
			$display("gated_pulse_feature_extractor test passed");
		else
			$display("gated_pulse_feature_extractor test failed");
		$finish;
	end

	// Run limit
	initial begin
		#20_000_000;
		$display("gated_pulse_feature_extractor test failed");
		$finish;
	end

endmodule
